// ===== design/voice_note_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// Voice note scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef VOICE_NOTE_SCHEDULER_ASSERT_SVH
`define VOICE_NOTE_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VNS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VNS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/vns_pkg.sv =====
// ----------------------------------------------------------------------------
// Voice note scheduler package
// Shared types, codes and default sizes of the voice note scheduler.
// ----------------------------------------------------------------------------
package vns_pkg;

	localparam int VOICE_COUNT_DEF   = 4;
	localparam int QUEUE_DEPTH_DEF   = 8;
	localparam int JITTER_PERIOD_DEF = 3;

	localparam int JIT_W     = 7;
	localparam int NIB_STEPS = 8;
	localparam int STEP_W    = 4;
	localparam int CMD_DEPTH = 2;

	localparam logic EV_NOTE_OFF = 1'b0;
	localparam logic EV_NOTE_ON  = 1'b1;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_PUSH = 2'd1,
		FUNC_STOP = 2'd2
	} func_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] tick_count;
		logic [1:0]  voice_index;
		logic        is_note;
		logic [6:0]  pitch;
		logic [6:0]  velocity_in;
		logic [15:0] duration;
	} req_t;

	typedef struct packed {
		logic        event_kind;
		logic [1:0]  event_voice;
		logic [6:0]  event_pitch;
		logic [6:0]  event_velocity;
		logic [3:0]  event_channel;
		logic        last_event;
	} note_ev_t;

	typedef struct packed {
		logic        is_note;
		logic [6:0]  pitch;
		logic [6:0]  velocity;
		logic [15:0] duration;
	} action_t;

	typedef struct packed {
		func_t             func;
		logic [31:0]       tick;
		logic [1:0]        voice;
		action_t           action;
		logic [JIT_W-1:0]  jitter;
	} cmd_t;

endpackage

// ===== design/voice_note_scheduler.sv =====
// Flow: the front end reduces the tick count of a tick request four bits at a time and then
// hands it to the command queue; the sequencer picks it up, visits each voice in turn (expiry
// and pop for a tick, note off for a stop) and closes the item. The front end holds one request
// and stalls the next until the held one is handed on; a push only writes a voice queue.
// Reset: arst_n clears all voice state, queue pointers and the channel to zero.
// ----------------------------------------------------------------------------
// Voice note scheduler
// Top level: channel configuration register, front end, command queue and
// voice sequencer.
// ----------------------------------------------------------------------------
module voice_note_scheduler #(
	parameter int VOICE_COUNT   = vns_pkg::VOICE_COUNT_DEF,
	parameter int QUEUE_DEPTH   = vns_pkg::QUEUE_DEPTH_DEF,
	parameter int JITTER_PERIOD = vns_pkg::JITTER_PERIOD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vns_pkg::req_t     req,
	input  logic              req_valid,
	output logic              req_stall,
	output vns_pkg::note_ev_t note_ev,
	output logic              note_ev_valid,
	input  logic              note_ev_stall,
	input  logic [3:0]        cfg_data,
	input  logic              cfg_valid,
	output logic              cfg_ready
);

	logic [3:0]    channel_q;
	vns_pkg::cmd_t f_cmd;
	logic          f_valid;
	logic          q_full;
	vns_pkg::cmd_t q_cmd;
	logic          q_valid;
	logic          q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			channel_q <= cfg_data;
		end
	end

	vns_front #(
		.VOICE_COUNT   (VOICE_COUNT),
		.JITTER_PERIOD (JITTER_PERIOD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (f_cmd),
		.cmd_valid (f_valid),
		.cmd_full  (q_full)
	);

	vns_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (f_cmd),
		.wr_valid (f_valid),
		.full     (q_full),
		.rd_cmd   (q_cmd),
		.rd_valid (q_valid),
		.rd_pop   (q_pop)
	);

	vns_back #(
		.VOICE_COUNT (VOICE_COUNT),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_cmd         (q_cmd),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.out_channel   (channel_q),
		.note_ev       (note_ev),
		.note_ev_valid (note_ev_valid),
		.note_ev_stall (note_ev_stall)
	);

endmodule

// ===== design/vns_front.sv =====
// ----------------------------------------------------------------------------
// Voice note scheduler front end
// Accepts requests, drops those with no effect, reduces the tick count
// modulo the jitter period four bits a cycle and hands commands on.
// ----------------------------------------------------------------------------
module vns_front #(
	parameter int VOICE_COUNT   = vns_pkg::VOICE_COUNT_DEF,
	parameter int JITTER_PERIOD = vns_pkg::JITTER_PERIOD_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  vns_pkg::req_t req,
	input  logic          req_valid,
	output logic          req_stall,
	output vns_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_full
);

	localparam int RED_W = vns_pkg::JIT_W + 4;

	logic                          hold_valid_q;
	vns_pkg::req_t                 hold_q;
	logic [31:0]                   tick_sh_q;
	logic [vns_pkg::JIT_W-1:0]     rem_q;
	logic [vns_pkg::STEP_W-1:0]    step_q;
	logic                          req_acc;
	logic                          keep;
	logic                          red_busy;
	logic [RED_W-1:0]              red;

	assign req_stall = hold_valid_q;
	assign req_acc   = req_valid && !req_stall;
	assign red_busy  = step_q != vns_pkg::STEP_W'(vns_pkg::NIB_STEPS);
	assign cmd_valid = hold_valid_q && !red_busy;

	always_comb begin
		keep = (req.func == vns_pkg::FUNC_TICK) || (req.func == vns_pkg::FUNC_STOP) ||
			((req.func == vns_pkg::FUNC_PUSH) && (int'(req.voice_index) < VOICE_COUNT));
	end

	always_comb begin
		red = {rem_q, tick_sh_q[31:28]};
		for (int b = 3; b >= 0; b--) begin
			if (red >= RED_W'(JITTER_PERIOD << b)) begin
				red = red - RED_W'(JITTER_PERIOD << b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			step_q       <= '0;
		end else begin
			if (req_acc) begin
				hold_valid_q <= keep;
				step_q       <= (req.func == vns_pkg::FUNC_TICK) ? '0 :
					vns_pkg::STEP_W'(vns_pkg::NIB_STEPS);
			end else begin
				if (cmd_valid && !cmd_full) begin
					hold_valid_q <= 1'b0;
				end
				if (hold_valid_q && red_busy) begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			hold_q    <= req;
			tick_sh_q <= req.tick_count;
			rem_q     <= '0;
		end else if (hold_valid_q && red_busy) begin
			tick_sh_q <= {tick_sh_q[27:0], 4'b0000};
			rem_q     <= red[vns_pkg::JIT_W-1:0];
		end
	end

	always_comb begin
		cmd.func            = vns_pkg::func_t'(hold_q.func);
		cmd.tick            = hold_q.tick_count;
		cmd.voice           = hold_q.voice_index;
		cmd.action.is_note  = hold_q.is_note;
		cmd.action.pitch    = hold_q.pitch;
		cmd.action.velocity = hold_q.velocity_in;
		cmd.action.duration = hold_q.duration;
		cmd.jitter          = rem_q;
	end

endmodule

// ===== design/vns_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// Voice note scheduler command queue
// Short queue that decouples the front end from the voice sequencer.
// ----------------------------------------------------------------------------
module vns_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  vns_pkg::cmd_t wr_cmd,
	input  logic          wr_valid,
	output logic          full,
	output vns_pkg::cmd_t rd_cmd,
	output logic          rd_valid,
	input  logic          rd_pop
);

	localparam int PW = $clog2(vns_pkg::CMD_DEPTH);
	localparam int CW = $clog2(vns_pkg::CMD_DEPTH + 1);

	vns_pkg::cmd_t  ent_q [vns_pkg::CMD_DEPTH];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign full     = cnt_q == CW'(vns_pkg::CMD_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_cmd   = ent_q[rp_q];
	assign do_wr    = wr_valid && !full;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wp_q] <= wr_cmd;
		end
	end

endmodule

// ===== design/vns_back.sv =====
// ----------------------------------------------------------------------------
// Voice note scheduler voice sequencer
// Holds the per-voice action queues and state, walks the voices for tick and
// stop commands and emits note events through a pending and an output stage.
// ----------------------------------------------------------------------------
`include "voice_note_scheduler_assert.svh"

module vns_back #(
	parameter int VOICE_COUNT = vns_pkg::VOICE_COUNT_DEF,
	parameter int QUEUE_DEPTH = vns_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vns_pkg::cmd_t     q_cmd,
	input  logic              q_valid,
	output logic              q_pop,
	input  logic [3:0]        out_channel,
	output vns_pkg::note_ev_t note_ev,
	output logic              note_ev_valid,
	input  logic              note_ev_stall
);

	localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXP  = 5'b00010,
		ST_POP  = 5'b00100,
		ST_STOP = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t                    st_q;
	logic [VW-1:0]             vi_q;
	logic [31:0]               tick_q;
	logic [vns_pkg::JIT_W-1:0] jit_q;

	logic                      play_q [VOICE_COUNT];
	logic [31:0]               exp_q  [VOICE_COUNT];
	vns_pkg::action_t          act_q  [VOICE_COUNT];
	logic [QW-1:0]             rp_q   [VOICE_COUNT];
	logic [QW-1:0]             wp_q   [VOICE_COUNT];
	logic [CW-1:0]             cnt_q  [VOICE_COUNT];
	vns_pkg::action_t          fifo_mem [VOICE_COUNT][QUEUE_DEPTH];
	vns_pkg::action_t          rd_q;

	logic                      pend_valid_q;
	vns_pkg::note_ev_t         pend_q;
	logic                      out_valid_q;
	vns_pkg::note_ev_t         out_q;

	logic [VW-1:0]             push_v;
	logic [VW-1:0]             idx;
	logic                      cur_play;
	logic [31:0]               cur_exp;
	vns_pkg::action_t          cur_act;
	logic [QW-1:0]             cur_rp;
	logic [QW-1:0]             cur_wp;
	logic [CW-1:0]             cur_cnt;
	logic                      exp_hit;
	logic                      can_pop;
	logic                      do_push;
	logic                      out_free;
	logic                      emit_ok;
	logic                      step_ok;
	logic                      fin_flush;
	logic                      ev_new_valid;
	vns_pkg::note_ev_t         ev_new;
	vns_pkg::note_ev_t         moved_ev;
	logic                      move_pend;
	logic                      last_voice;
	logic [16:0]               dur_jit;

	assign push_v   = VW'(q_cmd.voice);
	assign idx      = (st_q == ST_IDLE) ? push_v : vi_q;
	assign cur_play = play_q[idx];
	assign cur_exp  = exp_q[idx];
	assign cur_act  = act_q[idx];
	assign cur_rp   = rp_q[idx];
	assign cur_wp   = wp_q[idx];
	assign cur_cnt  = cnt_q[idx];
	assign exp_hit  = cur_play && (cur_exp == tick_q);
	assign can_pop  = !cur_play && (cur_cnt != '0);
	assign q_pop    = (st_q == ST_IDLE) && q_valid;
	assign do_push  = q_pop && (q_cmd.func == vns_pkg::FUNC_PUSH) &&
		(cur_cnt < CW'(QUEUE_DEPTH));
	assign out_free = !out_valid_q || !note_ev_stall;
	assign emit_ok  = !pend_valid_q || out_free;
	assign last_voice = vi_q == VW'(VOICE_COUNT - 1);
	assign dur_jit  = 17'(rd_q.duration) + 17'(jit_q);
	assign move_pend = pend_valid_q && (ev_new_valid || fin_flush);

	assign note_ev       = out_q;
	assign note_ev_valid = out_valid_q;

	always_comb begin
		ev_new_valid         = 1'b0;
		step_ok              = 1'b0;
		fin_flush            = 1'b0;
		ev_new.event_kind    = vns_pkg::EV_NOTE_OFF;
		ev_new.event_voice   = 2'(vi_q);
		ev_new.event_pitch   = cur_act.pitch;
		ev_new.event_velocity = '0;
		ev_new.event_channel = out_channel;
		ev_new.last_event    = 1'b0;
		case (st_q)
			ST_EXP: begin
				step_ok      = !(exp_hit && cur_act.is_note) || emit_ok;
				ev_new_valid = exp_hit && cur_act.is_note && emit_ok;
			end
			ST_POP: begin
				step_ok      = !(can_pop && rd_q.is_note) || emit_ok;
				ev_new_valid = can_pop && rd_q.is_note && emit_ok;
				ev_new.event_kind     = vns_pkg::EV_NOTE_ON;
				ev_new.event_pitch    = rd_q.pitch;
				ev_new.event_velocity = rd_q.velocity;
			end
			ST_STOP: begin
				step_ok      = emit_ok;
				ev_new_valid = emit_ok;
			end
			ST_FIN: begin
				step_ok   = !pend_valid_q || out_free;
				fin_flush = pend_valid_q && out_free;
			end
			default: begin
				step_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		moved_ev            = pend_q;
		moved_ev.last_event = fin_flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			vi_q         <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				play_q[i] <= 1'b0;
				exp_q[i]  <= '0;
				act_q[i]  <= '0;
				rp_q[i]   <= '0;
				wp_q[i]   <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (move_pend) begin
				out_valid_q <= 1'b1;
			end else if (!note_ev_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ev_new_valid) begin
				pend_valid_q <= 1'b1;
			end else if (fin_flush) begin
				pend_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						vi_q <= '0;
						case (q_cmd.func)
							vns_pkg::FUNC_TICK: begin
								st_q <= ST_EXP;
							end
							vns_pkg::FUNC_STOP: begin
								st_q <= ST_STOP;
							end
							default: begin
								st_q <= ST_IDLE;
							end
						endcase
						if (do_push) begin
							wp_q[push_v]  <= (cur_wp == QW'(QUEUE_DEPTH - 1)) ? '0 :
								cur_wp + 1'b1;
							cnt_q[push_v] <= cur_cnt + 1'b1;
						end
					end
				end
				ST_EXP: begin
					if (step_ok) begin
						if (exp_hit) begin
							play_q[vi_q] <= 1'b0;
						end
						st_q <= ST_POP;
					end
				end
				ST_POP: begin
					if (step_ok) begin
						if (can_pop) begin
							act_q[vi_q]  <= rd_q;
							exp_q[vi_q]  <= tick_q + 32'(dur_jit);
							play_q[vi_q] <= 1'b1;
							rp_q[vi_q]   <= (cur_rp == QW'(QUEUE_DEPTH - 1)) ? '0 :
								cur_rp + 1'b1;
							cnt_q[vi_q]  <= cur_cnt - 1'b1;
						end
						if (last_voice) begin
							st_q <= ST_FIN;
						end else begin
							vi_q <= vi_q + 1'b1;
							st_q <= ST_EXP;
						end
					end
				end
				ST_STOP: begin
					if (step_ok) begin
						if (last_voice) begin
							st_q <= ST_FIN;
						end else begin
							vi_q <= vi_q + 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (step_ok) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tick_q <= q_cmd.tick;
			jit_q  <= q_cmd.jitter;
		end
		if (ev_new_valid) begin
			pend_q <= ev_new;
		end
		if (move_pend) begin
			out_q <= moved_ev;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_mem[push_v][cur_wp] <= q_cmd.action;
		end
		if (st_q == ST_EXP) begin
			rd_q <= fifo_mem[vi_q][cur_rp];
		end
	end

	`VNS_ASSERT_IMP(a_idle_no_pending, st_q == ST_IDLE, !pend_valid_q, "pending event outside an item")
	`VNS_ASSERT_IMP(a_move_needs_slot, move_pend, out_free, "pending event moved into a busy output stage")
	`VNS_ASSERT_IMP(a_count_bound, 1'b1, cnt_q[vi_q] <= CW'(QUEUE_DEPTH), "voice queue count beyond its depth")
	`VNS_ASSERT_NXT(a_fin_clears, (st_q == ST_FIN) && step_ok, !pend_valid_q && (st_q == ST_IDLE), "item end left a pending event")

endmodule
